FILE: rtl/vopg_pkg.sv
package vopg_pkg;

	localparam int COL_W      = 12;
	localparam int BYTE_W     = 8;
	localparam int DIM_CFG_W  = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int PAT_W      = 3;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 32;
	localparam int HIT_W      = 3;

	// Reciprocal of three, scaled by two to the RECIP3_SHIFT, rounded up.
	localparam int RECIP3_SHIFT = 18;
	localparam int RECIP3_W     = 18;
	localparam logic [RECIP3_W-1:0] RECIP3 = RECIP3_W'(((1 << RECIP3_SHIFT) + 2) / 3);

	localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;
	localparam logic [BYTE_W-1:0] BYTE_MIN = 8'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_PATTERN      = 3'd2,
		REG_OVERLAY_MODE = 3'd3,
		REG_BYTE_ORDER   = 3'd4,
		REG_OVERLAY_Y    = 3'd5,
		REG_OVERLAY_U    = 3'd6,
		REG_OVERLAY_V    = 3'd7
	} cfg_index_t;

	localparam logic [PAT_W-1:0] PAT_OFF      = 3'd0;
	localparam logic [PAT_W-1:0] PAT_RECT     = 3'd1;
	localparam logic [PAT_W-1:0] PAT_SMALL_X  = 3'd2;
	localparam logic [PAT_W-1:0] PAT_LARGE_X  = 3'd3;
	localparam logic [PAT_W-1:0] PAT_THIRDS   = 3'd4;
	localparam logic [PAT_W-1:0] PAT_EXPOSURE = 3'd5;

	localparam logic ORDER_YUYV = 1'b0;
	localparam logic ORDER_UYVY = 1'b1;

	localparam logic MODE_REPLACE = 1'b0;
	localparam logic MODE_INVERT  = 1'b1;

	function automatic logic is_extreme(input logic [BYTE_W-1:0] b);
		return (b == BYTE_MAX) || (b == BYTE_MIN);
	endfunction

endpackage

FILE: rtl/video_overlay_pattern_generator_core.sv
// An input transfer is captured in the input register, and its result is registered in the
// output register once that register is free to take it.
// Throughput: one macropixel per cycle unless stalled; an input register and a result register
// hold one item each, and the input stalls only when both are full and the output is not ready.
// Reset (arst_n low, asynchronous) empties both registers and loads the configuration
// defaults; frame geometry is derived from the configuration and held in its own registers.
module video_overlay_pattern_generator_core #(
	parameter int MAX_DIM = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// column[11:0], line[23:12], in_byte0[31:24], in_byte1[39:32],
	// in_byte2[47:40], in_byte3[55:48]
	input  logic [vopg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// out_byte0[7:0], out_byte1[15:8], out_byte2[23:16], out_byte3[31:24]
	output logic [vopg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [vopg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vopg_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int CW = ((DW > vopg_pkg::COL_W) ? DW : vopg_pkg::COL_W) + 1;
	localparam int PW = DW + 1 + vopg_pkg::RECIP3_W;

	logic [vopg_pkg::DIM_CFG_W-1:0] frame_width_q, frame_height_q;
	logic [vopg_pkg::PAT_W-1:0]     pattern_q;
	logic                           overlay_mode_q, byte_order_q;
	logic [vopg_pkg::BYTE_W-1:0]    overlay_y_q, overlay_u_q, overlay_v_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= vopg_pkg::DIM_CFG_W'(640);
			frame_height_q <= vopg_pkg::DIM_CFG_W'(480);
			pattern_q      <= vopg_pkg::PAT_OFF;
			overlay_mode_q <= vopg_pkg::MODE_REPLACE;
			byte_order_q   <= vopg_pkg::ORDER_YUYV;
			overlay_y_q    <= 8'd0;
			overlay_u_q    <= 8'd128;
			overlay_v_q    <= 8'd128;
		end else if (cfg_valid && cfg_ready) begin
			unique case (vopg_pkg::cfg_index_t'(cfg_index))
				vopg_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				vopg_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				vopg_pkg::REG_PATTERN:      pattern_q      <= cfg_data[vopg_pkg::PAT_W-1:0];
				vopg_pkg::REG_OVERLAY_MODE: overlay_mode_q <= cfg_data[0];
				vopg_pkg::REG_BYTE_ORDER:   byte_order_q   <= cfg_data[0];
				vopg_pkg::REG_OVERLAY_Y:    overlay_y_q    <= cfg_data[vopg_pkg::BYTE_W-1:0];
				vopg_pkg::REG_OVERLAY_U:    overlay_u_q    <= cfg_data[vopg_pkg::BYTE_W-1:0];
				vopg_pkg::REG_OVERLAY_V:    overlay_v_q    <= cfg_data[vopg_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Frame geometry from the size registers.
	logic [DW-1:0]   sx, sy;
	logic [DW+3:0]   sx7, sx9, sy7, sy9;
	logic [DW:0]     sx2, sy2;
	logic [PW-1:0]   px1, px2, py1, py2;
	logic [DW-1:0]   is_d, ie_d, js_d, je_d, hy_d, cx_d, r1_d, r2_d, c1_d, c2_d;

	always_comb begin
		if (frame_width_q < vopg_pkg::DIM_CFG_W'(2)) begin
			sx = DW'(2);
		end else if (int'(frame_width_q) > MAX_DIM) begin
			sx = DW'(MAX_DIM);
		end else begin
			sx = DW'(frame_width_q);
		end
		if (frame_height_q < vopg_pkg::DIM_CFG_W'(2)) begin
			sy = DW'(2);
		end else if (int'(frame_height_q) > MAX_DIM) begin
			sy = DW'(MAX_DIM);
		end else begin
			sy = DW'(frame_height_q);
		end
		sx7 = (DW+4)'(sx) * (DW+4)'(7);
		sx9 = (DW+4)'(sx) * (DW+4)'(9);
		sy7 = (DW+4)'(sy) * (DW+4)'(7);
		sy9 = (DW+4)'(sy) * (DW+4)'(9);
		sx2 = {sx, 1'b0};
		sy2 = {sy, 1'b0};
		px1 = PW'(sx)  * PW'(vopg_pkg::RECIP3);
		px2 = PW'(sx2) * PW'(vopg_pkg::RECIP3);
		py1 = PW'(sy)  * PW'(vopg_pkg::RECIP3);
		py2 = PW'(sy2) * PW'(vopg_pkg::RECIP3);
		is_d = {sx7[DW+3:5], 1'b0};
		ie_d = {sx9[DW+3:5], 1'b0};
		js_d = sy7[DW+3:4];
		je_d = sy9[DW+3:4];
		hy_d = DW'(sy[DW-1:1]);
		cx_d = DW'({sx[DW-1:2], 1'b0});
		r1_d = py1[vopg_pkg::RECIP3_SHIFT +: DW];
		r2_d = py2[vopg_pkg::RECIP3_SHIFT +: DW];
		c1_d = {px1[vopg_pkg::RECIP3_SHIFT+1 +: DW-1], 1'b0};
		c2_d = {px2[vopg_pkg::RECIP3_SHIFT+1 +: DW-1], 1'b0};
	end

	logic [DW-1:0] sx_q, sy_q, is_q, ie_q, js_q, je_q, hy_q, cx_q, r1_q, r2_q, c1_q, c2_q;

	always_ff @(posedge clk) begin
		sx_q <= sx;
		sy_q <= sy;
		is_q <= is_d;
		ie_q <= ie_d;
		js_q <= js_d;
		je_q <= je_d;
		hy_q <= hy_d;
		cx_q <= cx_d;
		r1_q <= r1_d;
		r2_q <= r2_d;
		c1_q <= c1_d;
		c2_q <= c2_d;
	end

	// Input register and result register.
	logic                          vld_s1, out_vld_q;
	logic [vopg_pkg::IN_DATA_W-1:0] data_s1;
	logic [vopg_pkg::OUT_DATA_W-1:0] out_data_q, result;
	logic                          out_load, s1_load;

	assign out_load      = !out_vld_q || m_axis_tready;
	assign s_axis_tready = !vld_s1 || out_load;
	assign s1_load       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (out_load) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			data_s1 <= s_axis_tdata;
		end
		if (out_load && vld_s1) begin
			out_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// Stroke count and overlay for the item in the input register.
	logic [CW-1:0]              c, l, lp1;
	logic [vopg_pkg::BYTE_W-1:0] b0, b1, b2, b3;
	logic                        in_frame, hspan, vspan;
	logic [vopg_pkg::HIT_W-1:0]  hits;

	always_comb begin
		c   = CW'({data_s1[vopg_pkg::COL_W-1:1], 1'b0});
		l   = CW'(data_s1[2*vopg_pkg::COL_W-1:vopg_pkg::COL_W]);
		lp1 = l + CW'(1);
		b0  = data_s1[24 +: vopg_pkg::BYTE_W];
		b1  = data_s1[32 +: vopg_pkg::BYTE_W];
		b2  = data_s1[40 +: vopg_pkg::BYTE_W];
		b3  = data_s1[48 +: vopg_pkg::BYTE_W];

		in_frame = (c < CW'(sx_q)) && (l < CW'(sy_q));
		hspan    = (c >= CW'(is_q)) && (c <= CW'(ie_q));
		vspan    = (l >= CW'(js_q)) && (l <= CW'(je_q));

		hits = '0;
		if (in_frame) begin
			unique case (pattern_q)
				vopg_pkg::PAT_RECT: begin
					hits = (hspan ? (vopg_pkg::HIT_W'(l == CW'(js_q))
						+ vopg_pkg::HIT_W'(lp1 == CW'(js_q))
						+ vopg_pkg::HIT_W'(l == CW'(je_q))
						+ vopg_pkg::HIT_W'(l == CW'(je_q) + CW'(1))) : '0)
						+ (vspan ? (vopg_pkg::HIT_W'(c == CW'(is_q))
						+ vopg_pkg::HIT_W'(c == CW'(ie_q))) : '0);
				end
				vopg_pkg::PAT_SMALL_X: begin
					hits = (hspan ? (vopg_pkg::HIT_W'(l == CW'(hy_q))
						+ vopg_pkg::HIT_W'(lp1 == CW'(hy_q))) : '0)
						+ (vspan ? vopg_pkg::HIT_W'(c == CW'(cx_q)) : '0);
				end
				vopg_pkg::PAT_LARGE_X: begin
					hits = vopg_pkg::HIT_W'(l == CW'(hy_q))
						+ vopg_pkg::HIT_W'(lp1 == CW'(hy_q))
						+ vopg_pkg::HIT_W'(c == CW'(cx_q));
				end
				vopg_pkg::PAT_THIRDS: begin
					hits = vopg_pkg::HIT_W'(l == CW'(r1_q))
						+ vopg_pkg::HIT_W'(lp1 == CW'(r1_q))
						+ vopg_pkg::HIT_W'(l == CW'(r2_q))
						+ vopg_pkg::HIT_W'(lp1 == CW'(r2_q))
						+ vopg_pkg::HIT_W'(c == CW'(c1_q))
						+ vopg_pkg::HIT_W'(c == CW'(c2_q));
				end
				vopg_pkg::PAT_EXPOSURE: begin
					if (byte_order_q == vopg_pkg::ORDER_YUYV) begin
						hits = vopg_pkg::HIT_W'(vopg_pkg::is_extreme(b0)
							|| vopg_pkg::is_extreme(b2));
					end else begin
						hits = vopg_pkg::HIT_W'(vopg_pkg::is_extreme(b1)
							|| vopg_pkg::is_extreme(b3));
					end
				end
				default: hits = '0;
			endcase
		end

		result = {b3, b2, b1, b0};
		if (overlay_mode_q == vopg_pkg::MODE_REPLACE) begin
			if (hits != '0) begin
				if (byte_order_q == vopg_pkg::ORDER_YUYV) begin
					result = {overlay_v_q, overlay_y_q, overlay_u_q, overlay_y_q};
				end else begin
					result = {overlay_y_q, overlay_v_q, overlay_y_q, overlay_u_q};
				end
			end
		end else if (hits[0]) begin
			result = ~{b3, b2, b1, b0};
		end
	end

endmodule

FILE: rtl/vopg_checker.sv
module vopg_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [vopg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            cfg_ready
);

	// A stalled result holds until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// A result that appears on an empty output must follow its input transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without matching input transfer");

	// A draining output never blocks the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");

	// Reset empties the output, and configuration is always taken.
	assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid && cfg_ready)
		else $error("output valid during reset");

endmodule

bind video_overlay_pattern_generator_core vopg_checker u_vopg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);
